>>> design/gcpr_pkg.sv
`default_nettype none

package gcpr_pkg;

  // event codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_COLLECT = 1'b1;

  // integer divisor format
  localparam int          DIV_W        = 16;
  localparam logic [15:0] DIV_MAX      = 16'hFFFF;
  localparam logic [15:0] DIV_MIN      = 16'd1;
  localparam logic [15:0] DIV_RESET    = 16'd3;

  // integer part of the growth rate, held at 65536
  localparam int          GROWTH_INT_W   = 17;
  localparam logic [16:0] GROWTH_INT_MAX = 17'h10000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/gcpr_if.sv
`default_nettype none

interface gcpr_in_if #(parameter int BW = 48);
  logic          valid;
  logic          ready;
  logic          cmd;
  logic [BW-1:0] alloc_bytes;
  logic [BW-1:0] heap_bytes;
  logic [BW-1:0] image_bytes;
  logic [BW-1:0] total_alloc_bytes;

  modport source (output valid, cmd, alloc_bytes, heap_bytes, image_bytes,
                  total_alloc_bytes, input ready);
  modport sink (input valid, cmd, alloc_bytes, heap_bytes, image_bytes,
                total_alloc_bytes, output ready);
endinterface

interface gcpr_out_if #(parameter int BW = 48);
  logic          valid;
  logic          ready;
  logic          collect_request;
  logic [15:0]   divisor;
  logic          divisor_changed;
  logic [BW-1:0] budget_left;

  modport source (output valid, collect_request, divisor, divisor_changed,
                  budget_left, input ready);
  modport sink (input valid, collect_request, divisor, divisor_changed,
                budget_left, output ready);
endinterface

interface gcpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/gc_pressure_regulator_unit.sv
`default_nettype none

// channel  dir  handshake      payload
// item     in   valid/ready    cmd, alloc_bytes, heap_bytes, image_bytes, total_alloc_bytes
// result   out  valid/ready    collect_request, divisor, divisor_changed, budget_left
// cfg      in   valid/ready    data (min_divisor), always ready
//
// allocation event: result registered through the EVAL and EMIT states after the request is taken
// collection event with a rate update: passes EVAL, DIV when growth is divided, MUL, TGT,
// HYS and EMIT; the restoring divider in DIV produces one quotient bit per cycle
// one event at a time; the next request is taken while the last result waits
// synchronous reset restores the divisor 3, target 3.0 and a zero budget

module gc_pressure_regulator_unit import gcpr_pkg::*; #(
  parameter int BYTE_WIDTH = 48,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  gcpr_in_if.sink     item,
  gcpr_out_if.source  result,
  gcpr_cfg_if.sink    cfg
);

  localparam int BW     = BYTE_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int TW     = DIV_W + FB;
  localparam int GW     = GROWTH_INT_W + FB;
  localparam int PW     = DIV_W + GW;
  localparam int HYST_Q = ((6 << FRAC_BITS) / 10) + ((((6 << FRAC_BITS) % 10) >= 5) ? 1 : 0);

  localparam logic [GW-1:0] ONE_Q = GW'(1) << FB;
  localparam logic [TW:0]   HALF  = (TW+1)'(1) << (FB - 1);
  localparam logic [TW:0]   HYST  = (TW+1)'(HYST_Q);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_TGT  = 3'd4;
  localparam logic [2:0] S_HYS  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]    state;
  logic [15:0]   min_div;
  logic [15:0]   cur_div;
  logic [TW-1:0] target;
  logic [BW-1:0] budget;
  logic [BW-1:0] prev_image;
  logic [BW-1:0] prev_total;
  logic          req_r;
  logic          chg_r;
  logic          div_used;
  logic          res_valid;

  logic          cmd_r;
  logic [BW-1:0] alloc_r;
  logic [BW-1:0] heap_r;
  logic [BW-1:0] image_r;
  logic [BW-1:0] total_r;
  logic [PW-1:0] prod;
  logic          res_req;
  logic [15:0]   res_div;
  logic          res_chg;
  logic [BW-1:0] res_budget;

  logic          item_take;
  logic          res_free;
  logic          img_up;
  logic          all_up;
  logic [BW-1:0] dimg;
  logic [BW-1:0] dall;
  logic          rate_ok;
  logic          div_go;
  logic          div_start;
  div_stat_t     div_st;
  logic [GW-1:0] growth;
  logic [GW-1:0] factor;
  logic [TW-1:0] nt;
  logic [TW:0]   tsum;
  logic [TW-1:0] cur_q;
  logic          hyst_fire;
  logic [TW:0]   rnd;
  logic [16:0]   d17;
  logic [15:0]   d_new;
  logic [15:0]   cfg_min;

  assign item_take = item.valid & item.ready;
  assign res_free  = ~res_valid | result.ready;
  assign item.ready = state == S_IDLE;
  assign cfg.ready  = 1'b1;
  assign cfg_min    = (cfg.data == 16'd0) ? DIV_MIN : cfg.data;

  // rate inputs from the change since the last collection
  assign img_up    = image_r >= prev_image;
  assign all_up    = total_r > prev_total;
  assign dimg      = img_up ? image_r - prev_image : prev_image - image_r;
  assign dall      = all_up ? total_r - prev_total : prev_total - total_r;
  assign rate_ok   = (prev_image != '0) && (total_r != prev_total);
  assign div_go    = rate_ok && (dimg != '0) && (img_up == all_up);
  assign div_start = (state == S_EVAL) && (cmd_r == CMD_COLLECT) && div_go;

  gcpr_div #(.BW(BW), .FB(FB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dimg),
    .divisor  (dall),
    .stat     (div_st),
    .quot     (growth)
  );

  assign factor = ONE_Q + (div_used ? growth : '0);

  // new target saturates at the largest target value
  assign nt   = (|prod[PW-1:TW]) ? {TW{1'b1}} : prod[TW-1:0];
  assign tsum = {1'b0, target} + {1'b0, nt};

  assign cur_q     = {cur_div, {FB{1'b0}}};
  assign hyst_fire = ({1'b0, target} > ({1'b0, cur_q} + HYST)) ||
                     ({1'b0, cur_q} > ({1'b0, target} + HYST));
  assign rnd       = {1'b0, target} + HALF;
  assign d17       = rnd[TW:FB];
  assign d_new     = d17[16] ? DIV_MAX : ((d17[15:0] == 16'd0) ? DIV_MIN : d17[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      min_div    <= DIV_RESET;
      cur_div    <= DIV_RESET;
      target     <= {DIV_RESET, {FB{1'b0}}};
      budget     <= '0;
      prev_image <= '0;
      prev_total <= '0;
      req_r      <= 1'b0;
      chg_r      <= 1'b0;
      div_used   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        min_div <= cfg_min;
        cur_div <= cfg_min;
        target  <= {cfg_min, {FB{1'b0}}};
      end
      if (res_valid && result.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          chg_r    <= 1'b0;
          div_used <= div_go;
          if (cmd_r == CMD_ALLOC) begin
            if (alloc_r > budget) begin
              budget <= heap_r;
              req_r  <= 1'b1;
            end else begin
              budget <= budget - alloc_r;
              req_r  <= 1'b0;
            end
            state <= S_EMIT;
          end else begin
            req_r      <= 1'b0;
            budget     <= heap_r;
            prev_image <= image_r;
            prev_total <= total_r;
            if (!rate_ok) begin
              state <= S_EMIT;
            end else if (div_go) begin
              state <= S_DIV;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_TGT;
        end
        S_TGT: begin
          // a falling target only moves halfway down
          target <= (nt < target) ? tsum[TW:1] : nt;
          state  <= S_HYS;
        end
        S_HYS: begin
          if (hyst_fire) begin
            cur_div <= d_new;
            chg_r   <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cmd_r   <= item.cmd;
      alloc_r <= item.alloc_bytes;
      heap_r  <= item.heap_bytes;
      image_r <= item.image_bytes;
      total_r <= item.total_alloc_bytes;
    end
    if (state == S_MUL) begin
      prod <= PW'(min_div) * PW'(factor);
    end
    if ((state == S_EMIT) && res_free) begin
      res_req    <= req_r;
      res_div    <= cur_div;
      res_chg    <= chg_r;
      res_budget <= budget;
    end
  end

  assign result.valid           = res_valid;
  assign result.collect_request = res_req;
  assign result.divisor         = res_div;
  assign result.divisor_changed = res_chg;
  assign result.budget_left     = res_budget;

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    (div_st.busy || div_st.done) |-> (state == S_DIV))
    else $error("divider active outside its wait state");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.divisor != 16'd0))
    else $error("zero divisor reported");

  a_req_chg_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.collect_request && result.divisor_changed))
    else $error("collect request and divisor change on one result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_take |=> !item.ready)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire

>>> design/gcpr_div.sv
`default_nettype none

module gcpr_div import gcpr_pkg::*; #(
  parameter int BW = 48,
  parameter int FB = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [BW-1:0]                dividend,
  input  wire logic [BW-1:0]                divisor,
  output div_stat_t                         stat,
  output logic      [GROWTH_INT_W+FB-1:0]   quot
);

  localparam int STEPS = BW + FB;
  localparam int CW    = $clog2(STEPS + 1);

  logic                    busy;
  logic                    done;
  logic [CW-1:0]           cnt;
  logic [BW-1:0]           rem;
  logic [BW-1:0]           dvd;
  logic [BW-1:0]           dvs;
  logic [GROWTH_INT_W-1:0] qint;
  logic                    ovf;
  logic [FB-1:0]           qfrac;

  logic          int_phase;
  logic          in_bit;
  logic [BW:0]   r2;
  logic [BW+1:0] diff;
  logic          ge;
  logic          last;

  // one restoring step per cycle: dividend bits first, then zeros for the fraction
  assign int_phase = cnt < CW'(BW);
  assign in_bit    = int_phase ? dvd[BW-1] : 1'b0;
  assign r2        = {rem, in_bit};
  assign diff      = {1'b0, r2} - {2'b00, dvs};
  assign ge        = ~diff[BW+1];
  assign last      = cnt == CW'(STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= dividend;
      dvs   <= divisor;
      qint  <= '0;
      ovf   <= 1'b0;
      qfrac <= '0;
    end else if (busy) begin
      rem <= ge ? diff[BW-1:0] : r2[BW-1:0];
      if (int_phase) begin
        dvd  <= {dvd[BW-2:0], 1'b0};
        qint <= {qint[GROWTH_INT_W-2:0], ge};
        ovf  <= ovf | qint[GROWTH_INT_W-1];
      end else begin
        qfrac <= {qfrac[FB-2:0], ge};
      end
    end
  end

  assign quot = {((ovf || (qint > GROWTH_INT_MAX)) ? GROWTH_INT_MAX : qint), qfrac};
  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

>>> test/gcpr_regulation_check.sv
`default_nettype none

module gcpr_regulation_check import gcpr_pkg::*; #(
  parameter int BW   = 48,
  parameter int FRAC = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  gcpr_in_if        item,
  gcpr_out_if       result,
  gcpr_cfg_if       cfg,
  output int        mismatches,
  output int        outcomes_owed
);

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC;
  localparam logic [63:0] TGT_MAX = (64'd1 << (16 + FRAC)) - 64'd1;
  // 0.6 in fixed point, rounded to nearest
  localparam logic [63:0] HYST_Q  = ((64'd6 << FRAC) + 64'd5) / 64'd10;

  typedef struct packed {
    logic          collect_request;
    logic [15:0]   divisor;
    logic          divisor_changed;
    logic [BW-1:0] budget_left;
  } outcome_t;

  logic [BW-1:0]        budget;
  logic [BW-1:0]        last_image;
  logic [BW-1:0]        last_total;
  logic [16+FRAC-1:0]   target_q;
  logic [15:0]          cur_div;
  logic [15:0]          floor_div;
  outcome_t             outcomes_due[$];

  // growth rate as a fixed-point quotient, integer part held at its ceiling
  function automatic logic [63:0] frac_quotient(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] gap;
    int          i;
    whole = num / den;
    rem   = num % den;
    if (whole > 64'(GROWTH_INT_MAX)) whole = 64'(GROWTH_INT_MAX);
    q = whole;
    for (i = 0; i < FRAC; i++) begin
      gap = den - rem;
      q = q << 1;
      if (rem >= gap) begin
        rem = rem - gap;
        q[0] = 1'b1;
      end else begin
        rem = rem + rem;
      end
    end
    return q;
  endfunction

  function automatic outcome_t regulate(input logic ev_cmd, input logic [BW-1:0] size,
                                        input logic [BW-1:0] heap, input logic [BW-1:0] image,
                                        input logic [BW-1:0] total);
    outcome_t    v;
    logic        img_up;
    logic        tot_up;
    logic [63:0] d_img;
    logic [63:0] d_tot;
    logic [63:0] growth;
    logic [63:0] fresh;
    logic [63:0] cur_q;
    logic [63:0] rounded;
    v = '0;
    if (ev_cmd == CMD_ALLOC) begin
      if (size > budget) begin
        budget = heap;
        v.collect_request = 1'b1;
      end else begin
        budget = budget - size;
      end
    end else begin
      budget = heap;
      if (last_image != '0 && total != last_total) begin
        img_up = image >= last_image;
        tot_up = total > last_total;
        d_img = img_up ? 64'(image - last_image) : 64'(last_image - image);
        d_tot = tot_up ? 64'(total - last_total) : 64'(last_total - total);
        growth = '0;
        // shrinking image against growing allocation (or the reverse) counts as no growth
        if (d_img != '0 && img_up == tot_up) growth = frac_quotient(d_img, d_tot);
        if (growth > '0) fresh = 64'(floor_div) * (ONE_Q + growth);
        else fresh = 64'(floor_div) << FRAC;
        if (fresh > TGT_MAX) fresh = TGT_MAX;
        // decay toward a lower target, jump to a higher one
        if (fresh < 64'(target_q)) target_q = (16 + FRAC)'((64'(target_q) + fresh) >> 1);
        else target_q = (16 + FRAC)'(fresh);
        cur_q = 64'(cur_div) << FRAC;
        if (64'(target_q) > cur_q + HYST_Q || cur_q > 64'(target_q) + HYST_Q) begin
          rounded = (64'(target_q) + (ONE_Q >> 1)) >> FRAC;
          if (rounded > 64'(DIV_MAX)) rounded = 64'(DIV_MAX);
          if (rounded == '0) rounded = 64'(DIV_MIN);
          cur_div = rounded[15:0];
          v.divisor_changed = 1'b1;
        end
      end
      last_image = image;
      last_total = total;
    end
    v.divisor = cur_div;
    v.budget_left = budget;
    return v;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      budget = '0;
      last_image = '0;
      last_total = '0;
      floor_div = DIV_RESET;
      cur_div = DIV_RESET;
      target_q = (16 + FRAC)'(64'(DIV_RESET) << FRAC);
      outcomes_due.delete();
      mismatches = 0;
      outcomes_owed <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        floor_div = (cfg.data == '0) ? DIV_MIN : cfg.data;
        cur_div = floor_div;
        target_q = (16 + FRAC)'(64'(floor_div) << FRAC);
      end
      // results are matched before new requests are queued
      if (result.valid && result.ready) begin
        got.collect_request = result.collect_request;
        got.divisor = result.divisor;
        got.divisor_changed = result.divisor_changed;
        got.budget_left = result.budget_left;
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: req=%0b div=%0d chg=%0b budget=%0d",
                     got.collect_request, got.divisor, got.divisor_changed, got.budget_left);
        end else begin
          want = outcomes_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display(
                "mismatch: exp req=%0b div=%0d chg=%0b bud=%0d got req=%0b div=%0d chg=%0b bud=%0d",
                want.collect_request, want.divisor, want.divisor_changed,
                want.budget_left, got.collect_request, got.divisor,
                got.divisor_changed, got.budget_left);
          end
        end
      end
      if (item.valid && item.ready)
        outcomes_due.push_back(regulate(item.cmd, item.alloc_bytes, item.heap_bytes,
                                        item.image_bytes, item.total_alloc_bytes));
      outcomes_owed <= outcomes_due.size();
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
  import gcpr_pkg::*;

  localparam int BW          = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [BW-1:0] BYTES_MAX = '1;

  logic          clk;
  logic          rst;
  int            cycles = 0;
  int            mismatches;
  int            outcomes_owed;
  bit            send_burst = 1'b0;
  bit            take_burst = 1'b0;
  logic [BW-1:0] image_now = '0;
  logic [BW-1:0] total_now = '0;

  gcpr_in_if #(.BW(BW)) item_ch ();
  gcpr_out_if #(.BW(BW)) result_ch ();
  gcpr_cfg_if cfg_ch ();

  gc_pressure_regulator_unit #(.BYTE_WIDTH(BW), .FRAC_BITS(16)) uut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  gcpr_regulation_check #(.BW(BW), .FRAC(16)) regulation_check (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .outcomes_owed(outcomes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[gc_pressure_regulator_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [BW-1:0] wide_bytes();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[BW-1:0];
  endfunction

  task automatic offer(input logic c, input logic [BW-1:0] size, input logic [BW-1:0] heap,
                       input logic [BW-1:0] image, input logic [BW-1:0] total);
    int gap;
    if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= c;
    item_ch.alloc_bytes <= size;
    item_ch.heap_bytes <= heap;
    item_ch.image_bytes <= image;
    item_ch.total_alloc_bytes <= total;
    do @(posedge clk); while (!item_ch.ready);
    if (c == CMD_COLLECT) begin
      image_now = image;
      total_now = total;
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outcomes_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min(input logic [15:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a steady trace of growing image and allocation totals
  task automatic random_event();
    logic [BW-1:0] size;
    logic [BW-1:0] heap;
    logic [BW-1:0] image;
    logic [BW-1:0] total;
    logic [BW-1:0] step;
    heap = ($urandom_range(0, 9) == 0) ? wide_bytes() : BW'($urandom_range(0, 200000));
    step = BW'($urandom_range(1, 1 << 20));
    if ($urandom_range(0, 99) < 60) begin
      size = ($urandom_range(0, 9) == 0) ? wide_bytes() : BW'($urandom_range(0, 60000));
      offer(CMD_ALLOC, size, heap, wide_bytes(), wide_bytes());
    end else begin
      case ($urandom_range(0, 11))
        0: total = total_now;
        1: total = total_now - step;
        2: total = wide_bytes();
        default: total = total_now + step;
      endcase
      case ($urandom_range(0, 11))
        0: image = image_now;
        1: image = image_now - BW'($urandom_range(0, 1 << 22));
        2: image = wide_bytes();
        3: image = '0;
        default: image = image_now + BW'((64'(step) * $urandom_range(0, 400)) / 100);
      endcase
      offer(CMD_COLLECT, wide_bytes(), heap, image, total);
    end
  endtask

  // result side: random stalls, plus two long hold-offs to back up the input
  initial begin
    int stall;
    int taken;
    taken = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      taken++;
      if (taken == 120 || taken == 330) begin
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  initial begin
    int          phase;
    logic [15:0] floor_value;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_ALLOC;
    item_ch.alloc_bytes <= '0;
    item_ch.heap_bytes <= '0;
    item_ch.image_bytes <= '0;
    item_ch.total_alloc_bytes <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // budget: equal size leaves zero, larger size reloads and requests
    offer(CMD_ALLOC, '0, 48'd1000, '0, '0);
    offer(CMD_ALLOC, 48'd1, BYTES_MAX, '0, '0);
    offer(CMD_ALLOC, BYTES_MAX, '0, '0, '0);
    offer(CMD_ALLOC, BYTES_MAX, 48'd12345, '0, '0);
    offer(CMD_ALLOC, 48'd12345, '0, '0, '0);
    // first collection has no previous image, second has an unchanged total
    offer(CMD_COLLECT, BYTES_MAX, 48'd5000, 48'd1000000, 48'd10000);
    offer(CMD_COLLECT, '0, 48'd5000, 48'd1300000, 48'd10000);
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1600000, 48'd110000);
    // shrinking image, then shrinking total: no growth, target decays
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1500000, 48'd210000);
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1700000, 48'd200000);
    // both shrink: counts as growth
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1600000, 48'd150000);
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1600000, 48'd250000);
    // growth too small to show in the fraction
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1600001, BYTES_MAX);
    offer(CMD_COLLECT, '0, 48'd7000, 48'd1, '0);
    // huge growth saturates target and divisor
    offer(CMD_COLLECT, '0, BYTES_MAX, BYTES_MAX, 48'd1);
    offer(CMD_COLLECT, '0, '0, BYTES_MAX, 48'd2);
    // zero minimum is held at one; small growth stays inside the hysteresis band until a larger one crosses it
    write_min(16'd0);
    offer(CMD_COLLECT, '0, 48'd100, 48'd100, 48'd12);
    offer(CMD_COLLECT, '0, 48'd100, 48'd150, 48'd112);
    offer(CMD_COLLECT, '0, 48'd100, 48'd220, 48'd212);
    write_min(DIV_MAX);
    offer(CMD_COLLECT, '0, 48'd100, 48'd221, 48'd213);
    offer(CMD_ALLOC, 48'd50, 48'd100, '0, '0);

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: floor_value = DIV_MIN;
        1: floor_value = DIV_MAX;
        2: floor_value = 16'd2;
        3: floor_value = DIV_RESET;
        4: floor_value = 16'($urandom_range(4, 300));
        default: floor_value = 16'($urandom());
      endcase
      write_min(floor_value);
      repeat (75) random_event();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcomes_owed == 0)
      $display("[gc_pressure_regulator_unit] OK");
    else
      $display("[gc_pressure_regulator_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/gcpr_pkg.sv
design/gcpr_if.sv
design/gcpr_div.sv
design/gc_pressure_regulator_unit.sv
test/gcpr_regulation_check.sv
test/tb.sv
